FILE: hw/rtl/stk_pkg.sv
// shared types and constants for the stk500 bootloader engine
`timescale 1ns / 1ps
package stk_pkg;

    typedef enum logic [2:0] {
        K_TX    = 3'd0,
        K_ERASE = 3'd1,
        K_FILL  = 3'd2,
        K_WRITE = 3'd3,
        K_READ  = 3'd4,
        K_WDT   = 3'd5
    } kind_t;

    typedef enum logic [4:0] {
        PH_CMD, PH_PARAM, PH_SKIP_PLAIN, PH_SKIP_UNIV, PH_ADDR_LO, PH_ADDR_HI,
        PH_PROG_HI, PH_PROG_LO, PH_PROG_MEM, PH_PROG_DATA, PH_READ_HI,
        PH_READ_LO, PH_READ_MEM, PH_READ_WAIT, PH_SYNC_PLAIN, PH_SYNC_PARAM,
        PH_SYNC_UNIV, PH_SYNC_PROG, PH_SYNC_READ, PH_SYNC_SIGN
    } phase_t;

    // controller sequencer states
    typedef enum logic [2:0] {
        S_IDLE,   // waiting for input word
        S_EMIT,   // emitting a queued short list
        S_CLEAR,  // clearing page buffer after reset
        S_FRD,    // fill read: issue buffer reads
        S_FOUT,   // fill word presented
        S_WR,     // page write
        S_OK      // trailing ok
    } ctl_state_t;

    // datapath result selectors
    typedef enum logic [3:0] {
        R_WDT, R_INSYNC, R_OK, R_PARAM, R_ZERO, R_SIG0, R_SIG1, R_SIG2,
        R_ERASE, R_READ, R_FLASH, R_FILL, R_WRITE
    } res_t;

    typedef struct packed {
        logic   load_in;     // capture the input word
        logic   buf_we;      // write the page buffer
        logic   clr;         // buffer clear write of zero
        logic   fill_start;  // reset fill index
        logic   fill_step;   // issue a buffer read for a byte of the fill word
        logic   out_load;    // load output register
        res_t   sel;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic   out_busy;    // output register holds an undelivered word
        logic   clr_done;
        logic   fill_done;   // fill word offset past the page
        logic   fill_issued; // four reads issued for the current fill word
        logic   fill_word;   // four bytes gathered
    } dp_stat_t;

    localparam logic [7:0] SYNC_BYTE = 8'h20;
    localparam logic [7:0] INSYNC    = 8'h14;
    localparam logic [7:0] OK_BYTE   = 8'h10;
    localparam logic [7:0] WDT_VAL   = 8'h08;

endpackage

FILE: hw/rtl/stk_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module stk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hw/rtl/stk_datapath.sv
// datapath: input capture, address and counters, page buffer, fill gather, output register
`timescale 1ns / 1ps
module stk_datapath #(
    parameter int PAGE_BYTES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stk_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        byte_in,
    input  logic [15:0]       cursor,
    input  logic [7:0]        wr_index,
    input  logic              param_known,
    input  logic              out_ready,
    output stk_pkg::dp_stat_t stat,
    output logic              out_valid,
    output logic [2:0]        kind,
    output logic [15:0]       address,
    output logic [31:0]       data,
    output logic              last
);
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int FW = AW + 1;
    // fill walk covers the page rounded up to four
    localparam int FILL_END = ((PAGE_BYTES + 3) / 4) * 4;

    logic [7:0]    byte_reg;
    logic [AW:0]   clr_reg;
    logic [FW:0]   fidx_reg, fidx_next;   // read index
    logic [FW:0]   fbase_reg;             // byte offset of current fill word
    logic [1:0]    lane_reg;              // lane of the byte arriving from ram
    logic          rd_pend_reg;
    logic          rd_inpage_reg;
    logic [31:0]   fword_reg;
    logic [2:0]    gather_reg;
    logic          valid_reg;
    logic [2:0]    kind_reg;
    logic [15:0]   addr_reg;
    logic [31:0]   data_reg;
    logic          last_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    always_comb
    begin
        ram_we    = cmd.buf_we;
        ram_wdata = cmd.clr ? 8'h00 : byte_in;
        if (cmd.clr)
            ram_addr = clr_reg[AW-1:0];
        else if (cmd.buf_we)
            ram_addr = wr_index[AW-1:0];
        else
            ram_addr = fidx_reg[AW-1:0];
    end

    stk_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            byte_reg <= byte_in;
    end

    assign fidx_next = fidx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            fidx_reg      <= '0;
            fbase_reg     <= '0;
            lane_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            rd_inpage_reg <= 1'b0;
            fword_reg     <= '0;
            gather_reg    <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.fill_start)
            begin
                fidx_reg    <= '0;
                fbase_reg   <= '0;
                gather_reg  <= '0;
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.fill_step)
            begin
                // one read per cycle until four are issued for this word
                rd_pend_reg   <= 1'b1;
                rd_inpage_reg <= (fidx_reg < (FW+1)'(PAGE_BYTES));
                lane_reg      <= fidx_reg[1:0];
                fidx_reg      <= fidx_next;
            end
            else
            begin
                rd_pend_reg <= 1'b0;
            end
            if (rd_pend_reg && !cmd.fill_start)
            begin
                unique case (lane_reg)
                    2'd0: fword_reg[7:0]   <= rd_inpage_reg ? ram_rdata : 8'h00;
                    2'd1: fword_reg[15:8]  <= rd_inpage_reg ? ram_rdata : 8'h00;
                    2'd2: fword_reg[23:16] <= rd_inpage_reg ? ram_rdata : 8'h00;
                    2'd3: fword_reg[31:24] <= rd_inpage_reg ? ram_rdata : 8'h00;
                    default: ;
                endcase
                gather_reg <= gather_reg + 1'b1;
            end
            if (cmd.out_load && cmd.sel == stk_pkg::R_FILL)
            begin
                gather_reg <= '0;
                fbase_reg  <= fbase_reg + (FW+1)'(4);
            end
            if (cmd.out_load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            last_reg <= cmd.last;
            addr_reg <= 16'h0000;
            data_reg <= 32'h0;
            unique case (cmd.sel)
                stk_pkg::R_WDT:    begin kind_reg <= stk_pkg::K_WDT;
                                         data_reg <= {24'h0, stk_pkg::WDT_VAL}; end
                stk_pkg::R_INSYNC: begin kind_reg <= stk_pkg::K_TX;
                                         data_reg <= {24'h0, stk_pkg::INSYNC}; end
                stk_pkg::R_OK:     begin kind_reg <= stk_pkg::K_TX;
                                         data_reg <= {24'h0, stk_pkg::OK_BYTE}; end
                stk_pkg::R_PARAM:  begin kind_reg <= stk_pkg::K_TX;
                                         data_reg <= param_known ? 32'h04 : 32'h03; end
                stk_pkg::R_ZERO:   kind_reg <= stk_pkg::K_TX;
                stk_pkg::R_SIG0:   begin kind_reg <= stk_pkg::K_TX; data_reg <= 32'h1E; end
                stk_pkg::R_SIG1:   begin kind_reg <= stk_pkg::K_TX; data_reg <= 32'h95; end
                stk_pkg::R_SIG2:   begin kind_reg <= stk_pkg::K_TX; data_reg <= 32'h0F; end
                stk_pkg::R_ERASE:  begin kind_reg <= stk_pkg::K_ERASE; addr_reg <= cursor; end
                stk_pkg::R_READ:   begin kind_reg <= stk_pkg::K_READ; addr_reg <= cursor; end
                stk_pkg::R_FLASH:  begin kind_reg <= stk_pkg::K_TX;
                                         data_reg <= {24'h0, byte_reg}; end
                stk_pkg::R_FILL:   begin kind_reg <= stk_pkg::K_FILL;
                                         addr_reg <= cursor + 16'(fbase_reg);
                                         data_reg <= fword_reg; end
                stk_pkg::R_WRITE:  begin kind_reg <= stk_pkg::K_WRITE; addr_reg <= cursor; end
                default:           kind_reg <= stk_pkg::K_TX;
            endcase
        end
    end

    assign stat.out_busy    = valid_reg;
    assign stat.clr_done    = clr_reg[AW];
    assign stat.fill_done   = (fbase_reg >= (FW+1)'(FILL_END));
    assign stat.fill_issued = (fidx_reg == fbase_reg + (FW+1)'(4));
    assign stat.fill_word   = (gather_reg == 3'd4);

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign address   = addr_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    // a fill word is never shown before all four bytes are gathered
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.sel == stk_pkg::R_FILL |-> gather_reg == 3'd4)
        else $error("fill word loaded before gather complete");
    // output register is never overwritten while a word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !valid_reg || out_ready)
        else $error("output overwritten");
    // gather never overruns a word
    assert property (@(posedge clk) disable iff (!rst_n) gather_reg <= 3'd4)
        else $error("gather overrun");
endmodule

FILE: hw/rtl/stk_controller.sv
// controller: protocol phase machine and result sequencer
`timescale 1ns / 1ps
module stk_controller #(
    parameter int PAGE_BYTES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        byte_in,
    input  logic              out_ready,
    input  stk_pkg::dp_stat_t stat,
    output stk_pkg::dp_cmd_t  cmd,
    output logic [15:0]       cursor,
    output logic [7:0]        wr_index,
    output logic              param_known
);
    stk_pkg::ctl_state_t state_reg, state_next;
    stk_pkg::phase_t     phase_reg, phase_next;
    logic                halted_reg, halted_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [15:0]         cur_reg, cur_next;
    logic [7:0]          plen_reg, plen_next;
    logic                pk_reg, pk_next;
    // short queue of up to five results
    stk_pkg::res_t       q_reg [5], q_next [5];
    logic [2:0]          qn_reg, qn_next;
    logic [2:0]          qi_reg, qi_next;
    logic                tail_reg, tail_next;  // fills, write and ok follow the queue

    logic acc;
    logic can_out;

    assign acc     = in_valid && in_ready;
    assign can_out = !stat.out_busy || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stk_pkg::S_CLEAR;
            phase_reg  <= stk_pkg::PH_CMD;
            halted_reg <= 1'b0;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            plen_reg   <= '0;
            pk_reg     <= 1'b0;
            qn_reg     <= '0;
            qi_reg     <= '0;
            tail_reg   <= 1'b0;
            for (int i = 0; i < 5; i++)
                q_reg[i] <= stk_pkg::R_OK;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
            cnt_reg    <= cnt_next;
            cur_reg    <= cur_next;
            plen_reg   <= plen_next;
            pk_reg     <= pk_next;
            qn_reg     <= qn_next;
            qi_reg     <= qi_next;
            tail_reg   <= tail_next;
            q_reg      <= q_next;
        end
    end

    always_comb
    begin
        logic [7:0] cnt_dec;
        logic [7:0] cnt_inc;
        state_next  = state_reg;
        phase_next  = phase_reg;
        halted_next = halted_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        plen_next   = plen_reg;
        pk_next     = pk_reg;
        q_next      = q_reg;
        qn_next     = qn_reg;
        qi_next     = qi_reg;
        tail_next   = tail_reg;
        cmd         = '0;
        cmd.sel     = stk_pkg::R_OK;
        in_ready    = 1'b0;
        cnt_dec     = cnt_reg - 8'd1;
        cnt_inc     = cnt_reg + 8'd1;

        unique case (state_reg)
            stk_pkg::S_CLEAR:
            begin
                cmd.buf_we = 1'b1;
                cmd.clr    = 1'b1;
                if (stat.clr_done)
                begin
                    cmd.buf_we = 1'b0;
                    cmd.clr    = 1'b0;
                    state_next = stk_pkg::S_IDLE;
                end
            end
            stk_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (acc && !halted_reg)
                begin
                    cmd.load_in = 1'b1;
                    qn_next     = '0;
                    qi_next     = '0;
                    tail_next   = 1'b0;
                    if (action)
                    begin
                        if (phase_reg == stk_pkg::PH_READ_WAIT)
                        begin
                            q_next[0] = stk_pkg::R_FLASH;
                            cur_next  = cur_reg + 16'd1;
                            cnt_next  = cnt_dec;
                            q_next[1] = (cnt_dec != 0) ? stk_pkg::R_READ : stk_pkg::R_OK;
                            qn_next   = 3'd2;
                            if (cnt_dec == 0)
                                phase_next = stk_pkg::PH_CMD;
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            stk_pkg::PH_CMD:
                            begin
                                unique case (byte_in)
                                    8'h41: phase_next = stk_pkg::PH_PARAM;
                                    8'h42: begin cnt_next = 8'h14;
                                               phase_next = stk_pkg::PH_SKIP_PLAIN; end
                                    8'h45: begin cnt_next = 8'h05;
                                               phase_next = stk_pkg::PH_SKIP_PLAIN; end
                                    8'h55: phase_next = stk_pkg::PH_ADDR_LO;
                                    8'h56: begin cnt_next = 8'h04;
                                               phase_next = stk_pkg::PH_SKIP_UNIV; end
                                    8'h64: phase_next = stk_pkg::PH_PROG_HI;
                                    8'h74: phase_next = stk_pkg::PH_READ_HI;
                                    8'h75: phase_next = stk_pkg::PH_SYNC_SIGN;
                                    8'h51: begin q_next[0] = stk_pkg::R_WDT; qn_next = 3'd1;
                                               phase_next = stk_pkg::PH_SYNC_PLAIN; end
                                    default: phase_next = stk_pkg::PH_SYNC_PLAIN;
                                endcase
                            end
                            stk_pkg::PH_PARAM:
                            begin
                                pk_next    = (byte_in == 8'h81) || (byte_in == 8'h82);
                                phase_next = stk_pkg::PH_SYNC_PARAM;
                            end
                            stk_pkg::PH_SKIP_PLAIN, stk_pkg::PH_SKIP_UNIV:
                            begin
                                cnt_next = cnt_dec;
                                if (cnt_dec == 0)
                                    phase_next = (phase_reg == stk_pkg::PH_SKIP_UNIV)
                                               ? stk_pkg::PH_SYNC_UNIV
                                               : stk_pkg::PH_SYNC_PLAIN;
                            end
                            stk_pkg::PH_ADDR_LO:
                            begin
                                cur_next   = {8'h00, byte_in};
                                phase_next = stk_pkg::PH_ADDR_HI;
                            end
                            stk_pkg::PH_ADDR_HI:
                            begin
                                cur_next   = {byte_in[6:0], cur_reg[7:0], 1'b0};
                                phase_next = stk_pkg::PH_SYNC_PLAIN;
                            end
                            stk_pkg::PH_PROG_HI: phase_next = stk_pkg::PH_PROG_LO;
                            stk_pkg::PH_PROG_LO:
                            begin
                                plen_next  = byte_in;
                                phase_next = stk_pkg::PH_PROG_MEM;
                            end
                            stk_pkg::PH_PROG_MEM:
                            begin
                                q_next[0]  = stk_pkg::R_ERASE;
                                qn_next    = 3'd1;
                                cnt_next   = '0;
                                phase_next = (plen_reg == 0) ? stk_pkg::PH_SYNC_PROG
                                                             : stk_pkg::PH_PROG_DATA;
                            end
                            stk_pkg::PH_PROG_DATA:
                            begin
                                if (9'(cnt_reg) < 9'(PAGE_BYTES))
                                    cmd.buf_we = 1'b1;
                                cnt_next = cnt_inc;
                                if (cnt_inc >= plen_reg)
                                    phase_next = stk_pkg::PH_SYNC_PROG;
                            end
                            stk_pkg::PH_READ_HI: phase_next = stk_pkg::PH_READ_LO;
                            stk_pkg::PH_READ_LO:
                            begin
                                cnt_next   = byte_in;
                                phase_next = stk_pkg::PH_READ_MEM;
                            end
                            stk_pkg::PH_READ_MEM: phase_next = stk_pkg::PH_SYNC_READ;
                            stk_pkg::PH_READ_WAIT: ;
                            default:
                            begin
                                if (byte_in != stk_pkg::SYNC_BYTE)
                                begin
                                    q_next[0]   = stk_pkg::R_WDT;
                                    qn_next     = 3'd1;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    q_next[0]  = stk_pkg::R_INSYNC;
                                    phase_next = stk_pkg::PH_CMD;
                                    priority case (phase_reg)
                                        stk_pkg::PH_SYNC_PARAM:
                                        begin
                                            q_next[1] = stk_pkg::R_PARAM;
                                            q_next[2] = stk_pkg::R_OK; qn_next = 3'd3;
                                        end
                                        stk_pkg::PH_SYNC_UNIV:
                                        begin
                                            q_next[1] = stk_pkg::R_ZERO;
                                            q_next[2] = stk_pkg::R_OK; qn_next = 3'd3;
                                        end
                                        stk_pkg::PH_SYNC_PROG:
                                        begin
                                            qn_next = 3'd1; tail_next = 1'b1;
                                        end
                                        stk_pkg::PH_SYNC_SIGN:
                                        begin
                                            q_next[1] = stk_pkg::R_SIG0;
                                            q_next[2] = stk_pkg::R_SIG1;
                                            q_next[3] = stk_pkg::R_SIG2;
                                            q_next[4] = stk_pkg::R_OK; qn_next = 3'd5;
                                        end
                                        stk_pkg::PH_SYNC_READ:
                                        begin
                                            q_next[1]  = stk_pkg::R_READ; qn_next = 3'd2;
                                            phase_next = stk_pkg::PH_READ_WAIT;
                                        end
                                        default:
                                        begin
                                            q_next[1] = stk_pkg::R_OK; qn_next = 3'd2;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                    if (qn_next != 0)
                        state_next = stk_pkg::S_EMIT;
                end
            end
            stk_pkg::S_EMIT:
            begin
                if (can_out)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = q_reg[qi_reg];
                    cmd.last     = (qi_reg + 3'd1 == qn_reg) && !tail_reg;
                    qi_next      = qi_reg + 3'd1;
                    if (qi_reg + 3'd1 == qn_reg)
                    begin
                        if (tail_reg)
                        begin
                            cmd.fill_start = 1'b1;
                            state_next     = stk_pkg::S_FRD;
                        end
                        else
                            state_next = stk_pkg::S_IDLE;
                    end
                end
            end
            stk_pkg::S_FRD:
            begin
                if (stat.fill_done)
                    state_next = stk_pkg::S_WR;
                else if (stat.fill_word)
                    state_next = stk_pkg::S_FOUT;
                else
                    cmd.fill_step = !stat.fill_issued;
            end
            stk_pkg::S_FOUT:
            begin
                if (can_out)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = stk_pkg::R_FILL;
                    state_next   = stk_pkg::S_FRD;
                end
            end
            stk_pkg::S_WR:
            begin
                if (can_out)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = stk_pkg::R_WRITE;
                    state_next   = stk_pkg::S_OK;
                end
            end
            stk_pkg::S_OK:
            begin
                if (can_out)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = stk_pkg::R_OK;
                    cmd.last     = 1'b1;
                    state_next   = stk_pkg::S_IDLE;
                end
            end
            default: state_next = stk_pkg::S_IDLE;
        endcase
    end

    assign cursor      = cur_reg;
    assign wr_index    = cnt_reg;
    assign param_known = pk_reg;

    // input is only taken while no result sequence is running
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == stk_pkg::S_IDLE)
        else $error("input taken during sequence");
    // once halted, stays halted
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released");
    // buffer writes never overlap an output load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.buf_we |-> !cmd.out_load)
        else $error("buffer write during output");
endmodule

FILE: hw/rtl/stk500_bootloader_engine.sv
// top level of the stk500v1 bootloader protocol engine
`timescale 1ns / 1ps
// Each input word is a serial byte (action 0) or a flash read byte (action 1); the engine
// answers with a burst of result words, the final one marked by last. Once an input word
// is taken, the results follow back to back while out_ready is high; a page program sync
// emits PAGE_BYTES/4 fills (rounded up), each built in order: four page buffer ram reads
// issued one a cycle, the last byte landing in the fill word, the word seen complete and
// then loaded into the output register. A stalled out_ready holds the sequence.
// After reset the page buffer is cleared one entry per cycle, and no input word is
// accepted until the clear is done.
module stk500_bootloader_engine #(
    parameter int PAGE_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] address,
    output logic [31:0] data,
    output logic        last
);
    stk_pkg::dp_cmd_t  cmd;
    stk_pkg::dp_stat_t stat;
    logic [15:0]       cursor;
    logic [7:0]        wr_index;
    logic              param_known;

    // protocol sequencer
    stk_controller #(.PAGE_BYTES(PAGE_BYTES)) u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .byte_in     (byte_in),
        .out_ready   (out_ready),
        .stat        (stat),
        .cmd         (cmd),
        .cursor      (cursor),
        .wr_index    (wr_index),
        .param_known (param_known)
    );

    // buffer, fill gather and output register
    stk_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .byte_in     (byte_in),
        .cursor      (cursor),
        .wr_index    (wr_index),
        .param_known (param_known),
        .out_ready   (out_ready),
        .stat        (stat),
        .out_valid   (out_valid),
        .kind        (kind),
        .address     (address),
        .data        (data),
        .last        (last)
    );
endmodule

FILE: verif/stk500_bootloader_engine_tb.sv
// self-checking testbench for the stk500 bootloader engine
`timescale 1ns / 1ps
module stk500_bootloader_engine_tb;

    localparam int PAGE = 128;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [31:0] data;
        logic        last;
    } reply_t;

    typedef struct packed {
        logic       action;
        logic [7:0] value;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [7:0]  byte_in = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [15:0] address;
    logic [31:0] data;
    logic        last;

    stk500_bootloader_engine #(.PAGE_BYTES(PAGE)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .byte_in(byte_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .address(address), .data(data), .last(last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // protocol mirror state
    logic            m_halted;
    stk_pkg::phase_t m_phase;
    logic [7:0]      m_count;
    logic [15:0]     m_cursor;
    logic [7:0]      m_plen;
    logic            m_known;
    logic [7:0]      m_page [PAGE];

    word_t  pending_words[$];
    reply_t expected_replies[$];
    reply_t burst[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     calm = 1'b0;      // no idling in the last part
    bit     hold_long = 1'b0; // long receiver hold-off
    bit     in_taken = 1'b0;  // offered word was accepted at the last rising edge

    function automatic void push_reply(logic [2:0] k, logic [15:0] a, logic [31:0] d);
        reply_t r;
        r.kind = k;
        r.address = a;
        r.data = d;
        r.last = 1'b0;
        burst.push_back(r);
    endfunction

    function automatic logic [7:0] page_at(int i);
        return (i < PAGE) ? m_page[i] : 8'h00;
    endfunction

    // sync byte handling for all sync phases
    function automatic void sync_reply(logic [7:0] b);
        logic [31:0] w;
        if (b != stk_pkg::SYNC_BYTE)
        begin
            push_reply(stk_pkg::K_WDT, 16'h0, {24'h0, stk_pkg::WDT_VAL});
            m_halted = 1'b1;
            return;
        end
        push_reply(stk_pkg::K_TX, 16'h0, {24'h0, stk_pkg::INSYNC});
        case (m_phase)
            stk_pkg::PH_SYNC_PARAM:
                push_reply(stk_pkg::K_TX, 16'h0, m_known ? 32'h04 : 32'h03);
            stk_pkg::PH_SYNC_UNIV:
                push_reply(stk_pkg::K_TX, 16'h0, 32'h00);
            stk_pkg::PH_SYNC_SIGN:
            begin
                push_reply(stk_pkg::K_TX, 16'h0, 32'h1E);
                push_reply(stk_pkg::K_TX, 16'h0, 32'h95);
                push_reply(stk_pkg::K_TX, 16'h0, 32'h0F);
            end
            stk_pkg::PH_SYNC_PROG:
            begin
                for (int i = 0; i < PAGE; i += 4)
                begin
                    w = {page_at(i + 3), page_at(i + 2), page_at(i + 1), page_at(i)};
                    push_reply(stk_pkg::K_FILL, m_cursor + 16'(i), w);
                end
                push_reply(stk_pkg::K_WRITE, m_cursor, 32'h0);
            end
            stk_pkg::PH_SYNC_READ:
            begin
                push_reply(stk_pkg::K_READ, m_cursor, 32'h0);
                m_phase = stk_pkg::PH_READ_WAIT;
                return;
            end
            default: ;
        endcase
        push_reply(stk_pkg::K_TX, 16'h0, {24'h0, stk_pkg::OK_BYTE});
        m_phase = stk_pkg::PH_CMD;
    endfunction

    function automatic void serial_word(logic [7:0] b);
        case (m_phase)
            stk_pkg::PH_CMD:
                case (b)
                    8'h41: m_phase = stk_pkg::PH_PARAM;
                    8'h42: begin m_count = 8'h14; m_phase = stk_pkg::PH_SKIP_PLAIN; end
                    8'h45: begin m_count = 8'h05; m_phase = stk_pkg::PH_SKIP_PLAIN; end
                    8'h55: m_phase = stk_pkg::PH_ADDR_LO;
                    8'h56: begin m_count = 8'h04; m_phase = stk_pkg::PH_SKIP_UNIV; end
                    8'h64: m_phase = stk_pkg::PH_PROG_HI;
                    8'h74: m_phase = stk_pkg::PH_READ_HI;
                    8'h75: m_phase = stk_pkg::PH_SYNC_SIGN;
                    8'h51:
                    begin
                        push_reply(stk_pkg::K_WDT, 16'h0, {24'h0, stk_pkg::WDT_VAL});
                        m_phase = stk_pkg::PH_SYNC_PLAIN;
                    end
                    default: m_phase = stk_pkg::PH_SYNC_PLAIN;
                endcase
            stk_pkg::PH_PARAM:
            begin
                m_known = (b == 8'h81 || b == 8'h82);
                m_phase = stk_pkg::PH_SYNC_PARAM;
            end
            stk_pkg::PH_SKIP_PLAIN, stk_pkg::PH_SKIP_UNIV:
            begin
                m_count = m_count - 8'd1;
                if (m_count == 8'd0)
                    m_phase = (m_phase == stk_pkg::PH_SKIP_UNIV) ? stk_pkg::PH_SYNC_UNIV
                                                                 : stk_pkg::PH_SYNC_PLAIN;
            end
            stk_pkg::PH_ADDR_LO:
            begin
                m_cursor = {8'h00, b};
                m_phase = stk_pkg::PH_ADDR_HI;
            end
            stk_pkg::PH_ADDR_HI:
            begin
                m_cursor = {b, m_cursor[7:0]} << 1;
                m_phase = stk_pkg::PH_SYNC_PLAIN;
            end
            stk_pkg::PH_PROG_HI: m_phase = stk_pkg::PH_PROG_LO;
            stk_pkg::PH_PROG_LO:
            begin
                m_plen = b;
                m_phase = stk_pkg::PH_PROG_MEM;
            end
            stk_pkg::PH_PROG_MEM:
            begin
                push_reply(stk_pkg::K_ERASE, m_cursor, 32'h0);
                m_count = 8'd0;
                m_phase = (m_plen == 8'd0) ? stk_pkg::PH_SYNC_PROG : stk_pkg::PH_PROG_DATA;
            end
            stk_pkg::PH_PROG_DATA:
            begin
                if (m_count < PAGE)
                    m_page[m_count] = b;
                m_count = m_count + 8'd1;
                if (m_count >= m_plen)
                    m_phase = stk_pkg::PH_SYNC_PROG;
            end
            stk_pkg::PH_READ_HI: m_phase = stk_pkg::PH_READ_LO;
            stk_pkg::PH_READ_LO:
            begin
                m_count = b;
                m_phase = stk_pkg::PH_READ_MEM;
            end
            stk_pkg::PH_READ_MEM: m_phase = stk_pkg::PH_SYNC_READ;
            stk_pkg::PH_READ_WAIT: ;
            default: sync_reply(b);
        endcase
    endfunction

    function automatic void flash_word(logic [7:0] b);
        if (m_phase != stk_pkg::PH_READ_WAIT)
            return;
        push_reply(stk_pkg::K_TX, 16'h0, {24'h0, b});
        m_cursor = m_cursor + 16'd1;
        m_count = m_count - 8'd1;
        if (m_count != 8'd0)
            push_reply(stk_pkg::K_READ, m_cursor, 32'h0);
        else
        begin
            push_reply(stk_pkg::K_TX, 16'h0, {24'h0, stk_pkg::OK_BYTE});
            m_phase = stk_pkg::PH_CMD;
        end
    endfunction

    // predicts the replies of one accepted word
    function automatic void predict_replies(word_t w);
        burst.delete();
        if (m_halted)
            return;
        if (w.action)
            flash_word(w.value);
        else
            serial_word(w.value);
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            expected_replies.push_back(burst[i]);
    endfunction

    // stimulus helpers
    task automatic send(logic a, logic [7:0] b);
        word_t w;
        w.action = a;
        w.value = b;
        pending_words.push_back(w);
    endtask

    task automatic send_cmd(logic [7:0] c);
        send(1'b0, c);
    endtask

    // read page with flash replies answering each request
    task automatic send_read(logic [7:0] n, bit noisy);
        int cnt;
        send_cmd(8'h74);
        send_cmd(8'h00);
        send_cmd(n);
        send_cmd(8'h46);
        send_cmd(stk_pkg::SYNC_BYTE);
        cnt = (n == 0) ? 256 : n;
        for (int i = 0; i < cnt; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send(1'b0, 8'($urandom));  // ignored during a pending read
            send(1'b1, 8'($urandom));
        end
    endtask

    task automatic send_prog(logic [7:0] n);
        send_cmd(8'h64);
        send_cmd(8'h00);
        send_cmd(n);
        send_cmd(8'h46);
        for (int i = 0; i < n; i++)
            send_cmd(8'($urandom));
        send_cmd(stk_pkg::SYNC_BYTE);
    endtask

    task automatic send_addr(logic [7:0] lo, logic [7:0] hi);
        send_cmd(8'h55);
        send_cmd(lo);
        send_cmd(hi);
        send_cmd(stk_pkg::SYNC_BYTE);
    endtask

    // remembers whether the offered word went in at the rising edge
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
    end

    // driver: next word at the falling edge, random idle bursts
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;  // hold the offered word
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && (calm || $urandom_range(0, 5) != 0))
            begin
                in_valid <= 1'b1;
                action <= pending_words[0].action;
                byte_in <= pending_words[0].value;
                pending_words.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                if (!calm && pending_words.size() > 0)
                    send_gap <= $urandom_range(0, 9);
            end
        end
    end

    // receiver ready with idle bursts and a long hold-off
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_long)
                out_ready <= 1'b0;
            else if (calm)
                out_ready <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= $urandom_range(0, 9);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predict at input accept, check at output accept
    always @(posedge clk)
    begin
        reply_t got;
        reply_t exp_r;
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready)
            predict_replies('{action: action, value: byte_in});
        if (rst_n && out_valid && out_ready)
        begin
            got = '{kind: kind, address: address, data: data, last: last};
            if (expected_replies.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected reply kind=%0d addr=%h data=%h last=%b",
                             kind, address, data, last);
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (got !== exp_r)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("reply mismatch exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 exp_r.kind, exp_r.address, exp_r.data, exp_r.last,
                                 kind, address, data, last);
                end
            end
        end
    end

    // receiver hold-off while the sender keeps offering words
    initial
    begin
        int held;
        wait (rst_n);
        wait (expected_replies.size() > 4);
        hold_long = 1'b1;
        held = 0;
        while (held < 400)
        begin
            @(posedge clk);
            held++;
        end
        hold_long = 1'b0;
    end

    initial
    begin
        int pick;
        m_halted = 1'b0;
        m_phase = stk_pkg::PH_CMD;
        m_count = 8'd0;
        m_cursor = 16'd0;
        m_plen = 8'd0;
        m_known = 1'b0;
        for (int i = 0; i < PAGE; i++)
            m_page[i] = 8'h00;

        // directed: each command and the edge cases
        send_cmd(8'h41); send_cmd(8'h81); send_cmd(stk_pkg::SYNC_BYTE);
        send_cmd(8'h41); send_cmd(8'h82); send_cmd(stk_pkg::SYNC_BYTE);
        send_cmd(8'h41); send_cmd(8'hFF); send_cmd(stk_pkg::SYNC_BYTE);
        send(1'b1, 8'hFF);                       // stray flash byte
        send_cmd(8'h75); send_cmd(stk_pkg::SYNC_BYTE);
        send_cmd(8'h56); repeat (4) send_cmd(8'hFF); send_cmd(stk_pkg::SYNC_BYTE);
        send_cmd(8'h00); send_cmd(stk_pkg::SYNC_BYTE);    // unknown command
        send_cmd(8'h51); send_cmd(stk_pkg::SYNC_BYTE);
        send_addr(8'hFF, 8'hFF);                 // address wraps
        send_prog(8'd0);
        send_read(8'd2, 1'b0);
        send_cmd(8'h42); repeat (20) send_cmd(8'h00); send_cmd(stk_pkg::SYNC_BYTE);
        send_cmd(8'h45); repeat (5) send_cmd(8'h55); send_cmd(stk_pkg::SYNC_BYTE);
        send_addr(8'h00, 8'h00);
        send_prog(8'd130);                       // beyond the page
        send_read(8'd0, 1'b0);                   // count 0 means 256

        // random well-formed traffic with some noise
        while (pending_words.size() < 500)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin send_cmd(8'h41); send_cmd(8'($urandom));
                         send_cmd(stk_pkg::SYNC_BYTE); end
                1: begin send_cmd(8'h75); send_cmd(stk_pkg::SYNC_BYTE); end
                2: begin send_cmd(8'h56); repeat (4) send_cmd(8'($urandom));
                         send_cmd(stk_pkg::SYNC_BYTE); end
                3: send_addr(8'($urandom), 8'($urandom));
                4, 5: send_prog(8'($urandom_range(0, 40)));
                6: send_read(8'($urandom_range(1, 12)), 1'b1);
                7: begin send_cmd(8'h45); repeat (5) send_cmd(8'($urandom));
                         send_cmd(stk_pkg::SYNC_BYTE); end
                8: begin send_cmd(8'($urandom_range(128, 255)));  // unknown command
                         send_cmd(stk_pkg::SYNC_BYTE); end
                default: send(1'b1, 8'($urandom));
            endcase
        end
        // bad sync halts the engine, later words are ignored
        send_cmd(8'h75); send_cmd(8'h21);
        repeat (5) send(1'($urandom), 8'($urandom));

        #1;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() < 60);
        calm = 1'b1;
        wait (pending_words.size() == 0 && !(in_valid && !in_ready));
        @(posedge clk);
        wait (expected_replies.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog on run length
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
